// File: src/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, letter codes and the control program of the Roman numeral
// encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned LETTER_W = 7;
    localparam int unsigned BIN_W    = 12;   // holds every legal value
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned STEP_W   = 3;

    localparam logic [VALUE_W-1:0] MAX_VALUE = 16'd3999;

    // Reciprocal of ten: x / 10 == (x * RECIP10) >> RECIP_SH for x < 16384
    localparam logic [11:0] RECIP10  = 12'd3277;
    localparam int unsigned RECIP_SH = 15;

    localparam logic [LETTER_W-1:0] CH_NONE = 7'h00;
    localparam logic [LETTER_W-1:0] CH_I    = 7'h49;
    localparam logic [LETTER_W-1:0] CH_V    = 7'h56;
    localparam logic [LETTER_W-1:0] CH_X    = 7'h58;
    localparam logic [LETTER_W-1:0] CH_L    = 7'h4C;
    localparam logic [LETTER_W-1:0] CH_C    = 7'h43;
    localparam logic [LETTER_W-1:0] CH_D    = 7'h44;
    localparam logic [LETTER_W-1:0] CH_M    = 7'h4D;

    // Decimal positions
    localparam logic [1:0] POS_ONES  = 2'd0;
    localparam logic [1:0] POS_TENS  = 2'd1;
    localparam logic [1:0] POS_HUNDS = 2'd2;
    localparam logic [1:0] POS_THOUS = 2'd3;

    // Program addresses
    localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DIV0  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DIV1  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_DIV2  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_SEL   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd6;

    typedef enum logic [2:0] {
        OP_IDLE,     // wait for a command, capture the value
        OP_CHECK,    // emit the error result if the value is out of range
        OP_DIV,      // peel off one decimal digit
        OP_SEL,      // pick the leading nonzero digit
        OP_EMIT      // emit one letter
    } t_op;

    typedef enum logic [1:0] {
        C_NEXT,      // fall through to the next step
        C_START,     // go to the next step on a command, else hold
        C_BAD,       // jump to target on out of range, else fall through
        C_DONE       // jump to target after the final letter, else hold
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                digit_end;   // final letter of this digit
    } t_letter_info;

    function automatic t_ctrl ucode_rom(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w = '{op: OP_IDLE, cond: C_START, target: STEP_IDLE};
        case (step)
            STEP_IDLE:  w = '{op: OP_IDLE,  cond: C_START, target: STEP_IDLE};
            STEP_CHECK: w = '{op: OP_CHECK, cond: C_BAD,   target: STEP_IDLE};
            STEP_DIV0:  w = '{op: OP_DIV,   cond: C_NEXT,  target: STEP_IDLE};
            STEP_DIV1:  w = '{op: OP_DIV,   cond: C_NEXT,  target: STEP_IDLE};
            STEP_DIV2:  w = '{op: OP_DIV,   cond: C_NEXT,  target: STEP_IDLE};
            STEP_SEL:   w = '{op: OP_SEL,   cond: C_NEXT,  target: STEP_IDLE};
            STEP_EMIT:  w = '{op: OP_EMIT,  cond: C_DONE,  target: STEP_IDLE};
            default:    w = '{op: OP_IDLE,  cond: C_START, target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: src/rne_letter.sv
// ----------------------------------------------------------------------------
// rne_letter
// Letter picker: maps a digit, its position and the letter index within
// the digit to an ASCII letter, and flags the digit's final letter.
// ----------------------------------------------------------------------------
module rne_letter
    import rne_pkg::*;
(
    input  logic [1:0]         i_pos,
    input  logic [DIGIT_W-1:0] i_digit,
    input  logic [1:0]         i_idx,
    output t_letter_info       o_info
);

    logic [LETTER_W-1:0] unit_ch;
    logic [LETTER_W-1:0] five_ch;
    logic [LETTER_W-1:0] ten_ch;
    logic [1:0]          last_idx;
    logic [1:0]          kind;   // 0 unit, 1 five, 2 ten

    always_comb begin
        case (i_pos)
            POS_ONES:  begin unit_ch = CH_I; five_ch = CH_V; ten_ch = CH_X; end
            POS_TENS:  begin unit_ch = CH_X; five_ch = CH_L; ten_ch = CH_C; end
            POS_HUNDS: begin unit_ch = CH_C; five_ch = CH_D; ten_ch = CH_M; end
            default:   begin unit_ch = CH_M; five_ch = CH_D; ten_ch = CH_M; end
        endcase
    end

    always_comb begin
        kind     = 2'd0;
        last_idx = 2'd0;
        case (i_digit)
            4'd1, 4'd2, 4'd3: begin
                kind     = 2'd0;
                last_idx = 2'(i_digit - 4'd1);
            end
            4'd4: begin
                kind     = (i_idx == 2'd0) ? 2'd0 : 2'd1;
                last_idx = 2'd1;
            end
            4'd5, 4'd6, 4'd7, 4'd8: begin
                kind     = (i_idx == 2'd0) ? 2'd1 : 2'd0;
                last_idx = 2'(i_digit - 4'd5);
            end
            4'd9: begin
                kind     = (i_idx == 2'd0) ? 2'd0 : 2'd2;
                last_idx = 2'd1;
            end
            default: begin
                kind     = 2'd0;
                last_idx = 2'd0;
            end
        endcase
    end

    always_comb begin
        case (kind)
            2'd1:    o_info.letter = five_ch;
            2'd2:    o_info.letter = ten_ch;
            default: o_info.letter = unit_ch;
        endcase
        o_info.digit_end = (i_idx == last_idx);
    end

endmodule

// File: src/roman_numeral_encoder_top.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder_top
// Converts a binary integer into its Roman numeral, one ASCII letter per
// result strobe.
// ----------------------------------------------------------------------------
// A transfer starts when start is high while busy is low; i_value is taken
// at that edge. The numeral then appears one letter per cycle on o_letter,
// each marked by a single-cycle o_strobe, thousands first, with o_last on
// the final letter. The receiver cannot stall: every strobed letter must be
// taken in its cycle. A value of 0 or above 3999 yields one result with
// o_out_of_range and o_last set and o_letter zero. A numeral has 1 to 15
// letters, the most for 3888. The control program runs one step for the
// range check, three passes of the shared divide-by-ten unit to split out
// the digits, one step to find the leading digit, then the emit step once
// per letter, and each letter passes through the output register. Busy
// drops in the final letter's cycle, so a new start is accepted at the
// edge that ends that cycle.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_top
    import rne_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                busy,
    output logic                o_strobe,
    output logic [LETTER_W-1:0] o_letter,
    output logic                o_last,
    output logic                o_out_of_range
);

    // Highest nonzero position among those set in the mask
    function automatic logic [1:0] top_pos(input logic [3:0] nz);
        logic [1:0] p;
        p = POS_ONES;
        if (nz[3])      p = POS_THOUS;
        else if (nz[2]) p = POS_HUNDS;
        else if (nz[1]) p = POS_TENS;
        return p;
    endfunction

    // Sequencer
    logic [STEP_W-1:0]  r_step, n_step;
    t_ctrl              ctrl;

    // Datapath
    logic [BIN_W-1:0]   r_val;
    logic               r_bad;
    logic [DIGIT_W-1:0] r_dig [0:3];
    logic [1:0]         r_pos;
    logic [1:0]         r_idx;

    logic [23:0]        prod;
    logic [BIN_W-1:0]   quot;
    logic [BIN_W-1:0]   quot10;
    logic [DIGIT_W-1:0] rem;
    logic [3:0]         nz;
    logic [3:0]         nz_sel;
    logic [3:0]         below;
    logic [DIGIT_W-1:0] cur_digit;
    t_letter_info       info;
    logic               final_letter;

    assign ctrl = ucode_rom(r_step);
    assign busy = (r_step != STEP_IDLE);

    // Divide by ten through the reciprocal; remainder is the next digit
    assign prod   = 24'(r_val) * 24'(RECIP10);
    assign quot   = BIN_W'(prod >> RECIP_SH);
    assign quot10 = (quot << 3) + (quot << 1);
    assign rem    = DIGIT_W'(r_val - quot10);

    // Nonzero digit flags; during selection the thousands are still in r_val
    assign nz     = {r_dig[3] != '0, r_dig[2] != '0, r_dig[1] != '0, r_dig[0] != '0};
    assign nz_sel = {r_val != '0, nz[2:0]};

    // Positions strictly below the current one
    always_comb begin
        case (r_pos)
            POS_ONES:  below = 4'b0000;
            POS_TENS:  below = 4'b0001;
            POS_HUNDS: below = 4'b0011;
            default:   below = 4'b0111;
        endcase
    end

    assign cur_digit = r_dig[r_pos];

    rne_letter u_letter (
        .i_pos   (r_pos),
        .i_digit (cur_digit),
        .i_idx   (r_idx),
        .o_info  (info)
    );

    assign final_letter = info.digit_end && ((nz & below) == 4'b0000);

    // Next step from the control word's jump condition
    always_comb begin
        case (ctrl.cond)
            C_START: n_step = start ? (r_step + 3'd1) : r_step;
            C_BAD:   n_step = r_bad ? ctrl.target : (r_step + 3'd1);
            C_DONE:  n_step = final_letter ? ctrl.target : r_step;
            default: n_step = r_step + 3'd1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_IDLE;
            o_strobe <= 1'b0;
        end else begin
            r_step   <= n_step;
            o_strobe <= 1'b0;
            case (ctrl.op)
                OP_IDLE: begin
                    // Capture on transfer; flag the range now, while all bits are here
                    if (start) begin
                        r_val <= i_value[BIN_W-1:0];
                        r_bad <= (i_value == '0) || (i_value > MAX_VALUE);
                    end
                end
                OP_CHECK: begin
                    if (r_bad) begin
                        o_strobe       <= 1'b1;
                        o_letter       <= CH_NONE;
                        o_last         <= 1'b1;
                        o_out_of_range <= 1'b1;
                    end
                end
                OP_DIV: begin
                    // Shift the new digit in from the top: ones land in r_dig[0]
                    r_val    <= quot;
                    r_dig[2] <= rem;
                    r_dig[1] <= r_dig[2];
                    r_dig[0] <= r_dig[1];
                end
                OP_SEL: begin
                    r_dig[3] <= DIGIT_W'(r_val);
                    r_pos    <= top_pos(nz_sel);
                    r_idx    <= 2'd0;
                end
                OP_EMIT: begin
                    o_strobe       <= 1'b1;
                    o_letter       <= info.letter;
                    o_last         <= final_letter;
                    o_out_of_range <= 1'b0;
                    if (info.digit_end) begin
                        // Skip zero digits: jump to the next nonzero one below
                        r_pos <= top_pos(nz & below);
                        r_idx <= 2'd0;
                    end else begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Error result is always a lone, final, blank letter
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_out_of_range |-> o_last && (o_letter == CH_NONE))
        else $error("error result malformed");

    // Results only follow a busy cycle
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a pending item");

    // A transfer makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not start");

    // Letters of a good numeral are never blank
    a_letter_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_out_of_range |-> o_letter != CH_NONE)
        else $error("blank letter in numeral");

    // The final letter ends the item
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("busy after final letter");

endmodule

// File: verif/roman_numeral_encoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// roman_numeral_encoder_top_tb
// Self-checking bench for the Roman numeral encoder: each accepted value is
// encoded in the bench itself into the letters it should produce, and every
// strobed letter is compared against that queue in arrival order.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_top_tb;
    import rne_pkg::*;

    // One expected letter of a numeral, or the single error result
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
        logic                out_of_range;
    } t_numeral_letter;

    // ------------------------------------------------------------------------
    // Scoreboard: turns every accepted value into its expected letters and
    // checks the letters that come out of the block against them.
    // ------------------------------------------------------------------------
    class numeral_board;
        t_numeral_letter pending_letters[$];
        int mismatch_cnt;
        int values_taken;
        int values_rejected;
        int letters_checked;
        int longest_numeral;

        function new();
            mismatch_cnt    = 0;
            values_taken    = 0;
            values_rejected = 0;
            letters_checked = 0;
            longest_numeral = 0;
        endfunction

        function void push_letter(input logic [LETTER_W-1:0] ch);
            t_numeral_letter item;
            item.letter       = ch;
            item.last         = 1'b0;
            item.out_of_range = 1'b0;
            pending_letters.push_back(item);
        endfunction

        // Encode one decimal digit given its unit, five and ten letters
        function void push_digit(input int unsigned digit, input logic [LETTER_W-1:0] unit_ch,
                                 input logic [LETTER_W-1:0] five_ch,
                                 input logic [LETTER_W-1:0] ten_ch);
            int unsigned k;
            if (digit <= 3) begin
                for (k = 0; k < digit; k++) push_letter(unit_ch);
            end else if (digit == 4) begin
                push_letter(unit_ch);
                push_letter(five_ch);
            end else if (digit <= 8) begin
                push_letter(five_ch);
                for (k = 5; k < digit; k++) push_letter(unit_ch);
            end else begin
                push_letter(unit_ch);
                push_letter(ten_ch);
            end
        endfunction

        // Note an accepted value: append the letters of its numeral
        function void note_value(input logic [VALUE_W-1:0] value);
            int unsigned     v;
            int unsigned     k;
            int              first_idx;
            t_numeral_letter tail;
            v = value;
            values_taken++;
            if (v == 0 || v > MAX_VALUE) begin
                values_rejected++;
                tail.letter       = CH_NONE;
                tail.last         = 1'b1;
                tail.out_of_range = 1'b1;
                pending_letters.push_back(tail);
                return;
            end
            first_idx = pending_letters.size();
            for (k = 0; k < v / 1000; k++) push_letter(CH_M);
            push_digit((v / 100) % 10, CH_C, CH_D, CH_M);
            push_digit((v / 10) % 10, CH_X, CH_L, CH_C);
            push_digit(v % 10, CH_I, CH_V, CH_X);
            tail      = pending_letters[pending_letters.size() - 1];
            tail.last = 1'b1;
            pending_letters[pending_letters.size() - 1] = tail;
            if (pending_letters.size() - first_idx > longest_numeral)
                longest_numeral = pending_letters.size() - first_idx;
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] MISMATCH %s", $realtime, msg);
            mismatch_cnt++;
        endtask

        // Check one strobed letter against the oldest expectation
        task check_letter(input logic [LETTER_W-1:0] letter, input logic last,
                          input logic out_of_range);
            t_numeral_letter want;
            if (pending_letters.size() == 0) begin
                report_mismatch($sformatf("unexpected letter 0x%02h last=%0b oor=%0b",
                                          letter, last, out_of_range));
                return;
            end
            want = pending_letters.pop_front();
            letters_checked++;
            if (letter !== want.letter)
                report_mismatch($sformatf("letter 0x%02h, want 0x%02h", letter, want.letter));
            if (last !== want.last)
                report_mismatch($sformatf("last %0b, want %0b", last, want.last));
            if (out_of_range !== want.out_of_range)
                report_mismatch($sformatf("out_of_range %0b, want %0b",
                                          out_of_range, want.out_of_range));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic [VALUE_W-1:0]  i_value;
    logic                busy;
    logic                o_strobe;
    logic [LETTER_W-1:0] o_letter;
    logic                o_last;
    logic                o_out_of_range;

    numeral_board board = new();

    roman_numeral_encoder_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_value        (i_value),
        .busy           (busy),
        .o_strobe       (o_strobe),
        .o_letter       (o_letter),
        .o_last         (o_last),
        .o_out_of_range (o_out_of_range)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: the slowest legal run (about 230 values, each with its longest
    // gap and numeral) is under 15 us, so 200 us leaves a wide margin.
    initial begin
        #200000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitors. Both sample at the rising edge, before the block's registers
    // update, so they see the values that the edge itself acts on.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        // A transfer happens when start meets a low busy
        if (i_rst_n && start && !busy)
            board.note_value(i_value);
    end

    always @(posedge i_clk) begin
        // The block cannot be stalled: every strobe is a result taken now
        if (i_rst_n && o_strobe)
            board.check_letter(o_letter, o_last, o_out_of_range);
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks. Inputs only ever move at the falling edge.
    // ------------------------------------------------------------------------

    // Present one value after a gap of idle cycles, and hold start until the
    // transfer. With no gap, start stays high straight into the next value.
    task send_value(input logic [VALUE_W-1:0] value, input int unsigned gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start   <= 1'b0;
            i_value <= VALUE_W'($urandom);   // noise while idle must be ignored
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start and hold off until every outstanding letter has arrived
    task drain_letters();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.pending_letters.size() != 0) @(posedge i_clk);
    endtask

    // Mostly legal values, with zero and the whole out-of-range span mixed in
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 75) return VALUE_W'($urandom_range(1, 3999));
        if (sel < 80) return VALUE_W'(3888);        // longest numeral
        if (sel < 85) return '0;
        if (sel < 92) return VALUE_W'($urandom_range(4000, 4100));
        return VALUE_W'($urandom_range(4000, 65535));
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    logic [VALUE_W-1:0] directed_values[$] = '{
        16'd1, 16'd3999, 16'd0, 16'd4000, 16'd65535, 16'd3888,
        16'd4, 16'd9, 16'd8, 16'd88, 16'd800, 16'd444, 16'd999,
        16'd1000, 16'd3000, 16'd40, 16'd90, 16'd400, 16'd900,
        16'd49, 16'd1994, 16'd32768, 16'd3, 16'd2024
    };

    initial begin
        int  idx;
        int  burst_left;
        bit  burst;
        start   = 1'b0;
        i_value = '0;
        i_rst_n = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: range edges, every digit form, error values,
        // back to back with no gaps
        foreach (directed_values[k]) send_value(directed_values[k], 0);

        // Let everything settle once before the random part
        drain_letters();

        // Random part: mix stretches of back-to-back values with
        // stretches of random gaps, and drain now and then
        burst_left = 0;
        burst      = 1'b0;
        for (idx = 0; idx < 200; idx++) begin
            if (burst_left == 0) begin
                burst      = ($urandom_range(0, 3) == 0);
                burst_left = $urandom_range(5, 20);
            end
            burst_left--;
            if ($urandom_range(0, 39) == 0)
                drain_letters();
            send_value(pick_value(), burst ? 0 : $urandom_range(0, 9));
        end

        // Wind down: stop sending, wait for the tail, then a few idle cycles
        // to catch any stray strobe
        drain_letters();
        repeat (25) @(posedge i_clk);

        if (board.pending_letters.size() != 0)
            board.report_mismatch($sformatf("%0d letters never arrived",
                                            board.pending_letters.size()));

        $display("covered %0d values (%0d out of range), %0d letters checked",
                 board.values_taken, board.values_rejected, board.letters_checked);
        $display("longest numeral seen: %0d letters, mismatches: %0d",
                 board.longest_numeral, board.mismatch_cnt);

        if (board.mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: sim.f
src/rne_pkg.sv
src/rne_letter.sv
src/roman_numeral_encoder_top.sv
verif/roman_numeral_encoder_top_tb.sv
